FILE: hw/rtl/md4_pkg.sv
package md4_pkg;
    localparam logic [31:0] K1 = 32'h5A827999;
    localparam logic [31:0] K2 = 32'h6ED9EBA1;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int QUEUE_DEPTH = 2;

    // command from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       finish;
    } md4_cmd_t;

    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] j;
        begin
            j = i[3:0];
            if (i[5:4] == 2'd0) msg_idx = j;
            else if (i[5:4] == 2'd1) msg_idx = {j[1:0], j[3:2]};
            else msg_idx = {j[0], j[1], j[2], j[3]};
        end
    endfunction

    function automatic logic [4:0] rot_amt(input logic [1:0] r, input logic [1:0] s);
        logic [4:0] v;
        begin
            v = 5'd3;
            unique case (r)
                2'd0: case (s) 2'd0: v = 5'd3; 2'd1: v = 5'd7; 2'd2: v = 5'd11;
                          default: v = 5'd19; endcase
                2'd1: case (s) 2'd0: v = 5'd3; 2'd1: v = 5'd5; 2'd2: v = 5'd9;
                          default: v = 5'd13; endcase
                default: case (s) 2'd0: v = 5'd3; 2'd1: v = 5'd9; 2'd2: v = 5'd11;
                          default: v = 5'd15; endcase
            endcase
            rot_amt = v;
        end
    endfunction
endpackage

FILE: hw/rtl/md4_front.sv
module md4_front import md4_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_data_byte,
    input  logic       s_byte_present,
    input  logic       s_end_of_message,
    input  logic       s_valid,
    output logic       s_ready,
    output md4_cmd_t   cmd,
    output logic       cmd_valid,
    input  logic       cmd_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    md4_cmd_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic push, pop;

    // drop items that carry neither byte nor end
    assign s_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push = s_valid && s_ready && (s_byte_present || s_end_of_message);
    assign cmd_valid = (cnt_reg != '0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= '{data: s_data_byte, present: s_byte_present,
                                   finish: s_end_of_message};
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn) assert (cnt_reg <= (AW+1)'(DEPTH)) else $error("queue overflow");
    end
    property p_nopush_full;
        @(posedge aclk) disable iff (!aresetn) (cnt_reg == (AW+1)'(DEPTH)) |-> !push;
    endproperty
    a_nopush_full: assert property (p_nopush_full) else $error("push when full");
    property p_nopop_empty;
        @(posedge aclk) disable iff (!aresetn) (cnt_reg == '0) |-> !pop;
    endproperty
    a_nopop_empty: assert property (p_nopop_empty) else $error("pop when empty");
endmodule

FILE: hw/rtl/md4_back.sv
module md4_back import md4_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  md4_cmd_t    cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_valid,
    input  logic        m_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_RUN = 3'd1, ST_ADD = 3'd2,
                           ST_PAD = 3'd3, ST_OUT = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] v_reg [4];
    logic [31:0] blk_reg [16];
    logic [63:0] count_reg;
    logic [5:0]  step_reg;
    logic        fin_reg;      // finishing after this compression
    logic        second_reg;   // length block still to run
    logic        pad_done_reg; // padding already placed for this finish
    logic [1:0]  oidx_reg;

    logic [1:0]  t;
    logic [31:0] x, y, z, f, k, sum, rot;
    logic [4:0]  sh;
    logic [5:0]  pos;

    assign t = 2'd0 - step_reg[1:0];
    assign x = v_reg[t + 2'd1];
    assign y = v_reg[t + 2'd2];
    assign z = v_reg[t + 2'd3];
    assign sh = rot_amt(step_reg[5:4], step_reg[1:0]);
    assign sum = v_reg[t] + f + blk_reg[msg_idx(step_reg)] + k;
    assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    assign pos = count_reg[5:0];

    always_comb begin
        unique case (step_reg[5:4])
            2'd0: begin f = (x & y) | (~x & z); k = '0; end
            2'd1: begin f = (x & y) | (x & z) | (y & z); k = K1; end
            default: begin f = x ^ y ^ z; k = K2; end
        endcase
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[oidx_reg];
    assign m_word_index = oidx_reg;
    assign m_last_word = (oidx_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chain_reg <= '{IV0, IV1, IV2, IV3};
            count_reg <= '0;
            step_reg <= '0;
            fin_reg <= 1'b0;
            second_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            oidx_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (cmd_valid) begin
                    fin_reg <= cmd.finish;
                    if (cmd.present) begin
                        blk_reg[pos[5:2]][8*pos[1:0] +: 8] <= cmd.data;
                        count_reg <= count_reg + 64'd1;
                    end
                    if (cmd.present && pos == 6'd63) begin
                        v_reg <= chain_reg;
                        step_reg <= '0;
                        state_reg <= ST_RUN;
                    end else if (cmd.finish) begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    // place 0x80, clear the rest; length if it fits
                    for (int i = 0; i < 56; i++) begin
                        if (i[5:0] == pos) blk_reg[i/4][8*(i%4) +: 8] <= PAD_BYTE;
                        else if (i[5:0] > pos) blk_reg[i/4][8*(i%4) +: 8] <= 8'h00;
                    end
                    if (pos < 6'd56) begin
                        blk_reg[14] <= {count_reg[28:0], 3'b000};
                        blk_reg[15] <= count_reg[60:29];
                        second_reg <= 1'b0;
                    end else begin
                        for (int i = 56; i < 64; i++) begin
                            if (i[5:0] == pos) blk_reg[i/4][8*(i%4) +: 8] <= PAD_BYTE;
                            else if (i[5:0] > pos) blk_reg[i/4][8*(i%4) +: 8] <= 8'h00;
                        end
                        second_reg <= 1'b1;
                    end
                    v_reg <= chain_reg;
                    step_reg <= '0;
                    fin_reg <= 1'b1;
                    pad_done_reg <= 1'b1;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    v_reg[t] <= rot;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd47) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 4; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
                    if (second_reg) begin
                        second_reg <= 1'b0;
                        for (int i = 0; i < 14; i++) blk_reg[i] <= '0;
                        blk_reg[14] <= {count_reg[28:0], 3'b000};
                        blk_reg[15] <= count_reg[60:29];
                        v_reg[0] <= chain_reg[0] + v_reg[0];
                        v_reg[1] <= chain_reg[1] + v_reg[1];
                        v_reg[2] <= chain_reg[2] + v_reg[2];
                        v_reg[3] <= chain_reg[3] + v_reg[3];
                        step_reg <= '0;
                        state_reg <= ST_RUN;
                    end else if (fin_reg) begin
                        // a block completed by a byte with end still needs padding
                        if (pad_done_reg) begin
                            oidx_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_PAD;
                        end
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: if (m_ready) begin
                    oidx_reg <= oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3) begin
                        chain_reg <= '{IV0, IV1, IV2, IV3};
                        count_reg <= '0;
                        fin_reg <= 1'b0;
                        pad_done_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    property p_out_stable;
        @(posedge aclk) disable iff (!aresetn) (m_valid && !m_ready) |=> m_valid;
    endproperty
    a_out_stable: assert property (p_out_stable) else $error("result dropped");
    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_RUN) |-> !cmd_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");
    property p_last_wraps;
        @(posedge aclk) disable iff (!aresetn) (m_valid && m_ready && m_last_word)
            |=> (state_reg == ST_IDLE && count_reg == '0);
    endproperty
    a_last_wraps: assert property (p_last_wraps) else $error("no reinit after digest");
endmodule

FILE: hw/rtl/md4_hash_engine_unit.sv
// MD4 digest engine.
// Input channel s_*: one item per byte (s_byte_present) with s_end_of_message
// closing the message; an item with neither flag is taken and dropped.
// Items enter a two-entry queue, so the sender can place two more items
// while the back end compresses; then s_ready falls until one is taken.
// The back end takes one queued item per cycle while it is
// gathering bytes; the item that fills a 64-byte block holds it
// through the compression (48 rounds, one per cycle, on a single round
// unit, then the chaining add).
// A finishing item is padded in ST_PAD and compresses once or twice:
// twice when the length needs a block of its own or the item also
// filled a block.
// Output channel m_*: four items, word 0 first, m_last_word on word 3.
// While the receiver stalls the current word is held and no further
// queued item is processed; the queue fills and then s_ready falls.
// After the last word the chaining state returns to the initial values.
// Reset (aresetn low, synchronous) empties the queue, loads the initial
// chaining words and clears the byte count.
module md4_hash_engine_unit import md4_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_valid,
    input  logic        m_ready
);
    md4_cmd_t cmd;
    logic cmd_valid, cmd_ready;

    md4_front #(.DEPTH(DEPTH)) u_front (
        .aclk, .aresetn, .s_data_byte, .s_byte_present, .s_end_of_message,
        .s_valid, .s_ready, .cmd, .cmd_valid, .cmd_ready
    );

    md4_back u_back (
        .aclk, .aresetn, .cmd, .cmd_valid, .cmd_ready,
        .m_digest_word, .m_word_index, .m_last_word, .m_valid, .m_ready
    );
endmodule

FILE: bench/md4_hash_engine_unit_test.sv
module md4_hash_engine_unit_test;
    import md4_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_out_t;

    class digest_scoreboard;
        logic [31:0] chain [4];
        logic [31:0] blk [16];
        logic [63:0] nbytes;
        digest_out_t pending [$];
        int errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = IV0;
            chain[1] = IV1;
            chain[2] = IV2;
            chain[3] = IV3;
            for (int i = 0; i < 16; i++) blk[i] = '0;
            nbytes = '0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int s);
            rotl = (s == 0) ? x : ((x << s) | (x >> (32 - s)));
        endfunction

        function void put_byte(int pos, logic [7:0] b);
            blk[pos / 4][(pos % 4) * 8 +: 8] = b;
        endfunction

        function void compress();
            logic [31:0] v [4];
            logic [31:0] f, k, x, y, z;
            int t, rnd, j, mi, sh;
            int shifts [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
            int perm3 [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
            for (int i = 0; i < 4; i++) v[i] = chain[i];
            for (int i = 0; i < 48; i++) begin
                t = (4 - (i % 4)) % 4;
                x = v[(t + 1) % 4];
                y = v[(t + 2) % 4];
                z = v[(t + 3) % 4];
                rnd = i / 16;
                j = i % 16;
                if (rnd == 0) begin
                    f = (x & y) | (~x & z);
                    k = 0;
                    mi = j;
                end else if (rnd == 1) begin
                    f = (x & y) | (x & z) | (y & z);
                    k = K1;
                    mi = (j % 4) * 4 + j / 4;
                end else begin
                    f = x ^ y ^ z;
                    k = K2;
                    mi = perm3[j];
                end
                sh = shifts[rnd * 4 + i % 4];
                v[t] = rotl(v[t] + f + blk[mi] + k, sh);
            end
            for (int i = 0; i < 4; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void note_item(logic [7:0] d, logic present, logic finish);
            int pos;
            digest_out_t e;
            if (present) begin
                put_byte(nbytes[5:0], d);
                nbytes = nbytes + 1;
                if (nbytes[5:0] == 0) compress();
            end
            if (!finish) return;
            pos = nbytes[5:0];
            put_byte(pos, PAD_BYTE);
            for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
            if (pos >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            blk[14] = {nbytes[28:0], 3'b000};
            blk[15] = nbytes[60:29];
            compress();
            for (int i = 0; i < 4; i++) begin
                e.word = chain[i];
                e.index = 2'(i);
                e.last = (i == 3);
                pending.push_back(e);
            end
            restart();
        endfunction

        function void check_word(logic [31:0] w, logic [1:0] idx, logic last);
            digest_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected digest word %h", w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.word) begin
                $error("digest_word: expected %h, got %h", e.word, w);
                errors++;
            end
            if (idx !== e.index) begin
                $error("word_index: expected %0d, got %0d", e.index, idx);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_word: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic [7:0]  s_data_byte = 0;
    logic        s_byte_present = 0;
    logic        s_end_of_message = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] m_digest_word;
    logic [1:0]  m_word_index;
    logic        m_last_word;
    logic        m_valid;
    logic        m_ready = 0;

    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;
    digest_scoreboard board;

    md4_hash_engine_unit uut (.*);

    always #4 aclk = ~aclk;

    // one item per call; gaps drawn before offering, valid left high on return
    task automatic send_item(logic [7:0] d, logic present, logic finish);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_data_byte <= d;
        s_byte_present <= present;
        s_end_of_message <= finish;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(d, present, finish);
        @(negedge aclk);
    endtask

    task automatic send_message(int len, bit empty_finish);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0) send_item(8'($urandom), 0, 0);
            send_item(8'($urandom), 1, empty_finish ? 0 : (i == len - 1));
        end
        if (empty_finish || len == 0) send_item(8'($urandom), 0, 1);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word(m_digest_word, m_word_index, m_last_word);
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int lens [8] = '{55, 56, 64, 0, 1, 2, 3, 4};
        int phase_idle [4] = '{0, 57, 0, 36};
        int phase_stall [4] = '{0, 0, 57, 36};
        board = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: empty message, extremes, pad boundaries
        send_item(8'h00, 0, 0);
        send_item(8'hff, 0, 1);
        send_item(8'hff, 1, 1);
        send_item(8'h00, 1, 1);
        send_item(8'h61, 1, 0);
        send_item(8'h62, 1, 0);
        send_item(8'h63, 1, 0);
        send_item(8'h00, 0, 1);
        for (int i = 0; i < 8; i++) send_message(lens[i], i[0]);

        // fill the queue against a stalled receiver
        send_message(3, 0);
        hold_off = 400;
        for (int i = 0; i < 3; i++) send_message(2, 0);

        for (int p = 0; p < 4; p++) begin
            send_idle = phase_idle[p];
            recv_stall = phase_stall[p];
            for (int m = 0; m < 4; m++)
                send_message($urandom_range(1, 4), 1'($urandom_range(1)));
        end
        s_valid <= 0;
        send_idle = 0;
        recv_stall = 0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/md4_pkg.sv
hw/rtl/md4_front.sv
hw/rtl/md4_back.sv
hw/rtl/md4_hash_engine_unit.sv
bench/md4_hash_engine_unit_test.sv
